/* rtl/dltq_pkg.sv */
// Package for the delta-list timer queue: sizes, link encoding, action and
// status codes, and the sequencer state type. No dependencies.
package dltq_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int NUM_LISTS  = 4;
   localparam int COUNT_BITS = 32;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LINK_W = SLOT_W + 1;
   localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int CNT_W  = COUNT_BITS;
   localparam int CFG_W  = LIST_W + CNT_W;

   localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NUM_SLOTS);

   typedef enum logic [2:0] {
      ACT_START   = 3'd0,
      ACT_RESTART = 3'd1,
      ACT_STOP    = 3'd2,
      ACT_QUERY   = 3'd3,
      ACT_TICK    = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_BAD_LIST = 3'd1,
      ST_INACTIVE = 3'd2,
      ST_EXPIRED  = 3'd3,
      ST_ZERO_DUR = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UL_A,
      S_UL_B,
      S_LK_START,
      S_LK_WALK,
      S_LK_FIX,
      S_LK_TAIL,
      S_TK_CHK,
      S_TK_NEXT,
      S_QR_WALK,
      S_EMIT
   } state_type;

   function automatic logic is_null(input logic [LINK_W-1:0] link);
      return link >= NONE_LINK;
   endfunction

endpackage

/* rtl/dltq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module dltq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

/* rtl/delta_list_timer_queue_core.sv */
// Delta-list timer queue, top level. Uses dltq_pkg and dltq_ram.
// Holds the link and delta memories and the sequencer that walks them.
//
// The core keeps NUM_SLOTS timer slots on NUM_LISTS lists, each list ordered
// by expiry with every entry storing its time relative to the entry before.
// One request transaction is worked on at a time; while it runs, req_stall
// is high. The next, previous and delta fields live in three synchronous
// memories with a registered read, which each step of a list walk reads.
// A start searches its place along the list (unlinking the timer first if it
// was active), a query sums the deltas from the timer back to the head, a
// stop unlinks the timer, and a tick charges its amount to the head and
// unlinks every timer that expires. Each response transaction passes through
// an output register, so a new request can be taken while the last response
// still waits under rsp_stall. A tick gives one expired notice per expired
// slot in expiry order, the final one flagged by rsp_last; all other requests
// give a single response.
module delta_list_timer_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_timer_id,
   input  logic [1:0]  req_list_type,
   input  logic [31:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_expired_id,
   output logic [31:0] rsp_remaining,
   output logic        rsp_last
);
   import dltq_pkg::*;

   // Sequencer and working registers.
   state_type          state_ff, state_in;
   logic [2:0]         act_ff, act_in;
   logic [SLOT_W-1:0]  id_ff, id_in;
   logic [1:0]         lt_ff, lt_in;
   logic [CNT_W-1:0]   amt_ff, amt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]   cum_ff, cum_in;
   logic [CNT_W-1:0]   v_ff, v_in;
   logic [LIST_W-1:0]  lst_ff, lst_in;
   logic [LIST_W-1:0]  ul_list_ff, ul_list_in;
   logic [LINK_W-1:0]  nxr_ff, nxr_in;
   logic [LINK_W-1:0]  pvr_ff, pvr_in;
   logic [CNT_W-1:0]   dr_ff, dr_in;

   // Staged response and where to go once it is loaded.
   status_type         em_status_ff, em_status_in;
   logic [5:0]         em_id_ff, em_id_in;
   logic [CNT_W-1:0]   em_rem_ff, em_rem_in;
   logic               em_last_ff, em_last_in;
   state_type          em_next_ff, em_next_in;

   // List heads, active flags and valid bits of the start record memory.
   logic [LINK_W-1:0]    head_ff [NUM_LISTS];
   logic [LINK_W-1:0]    head_in [NUM_LISTS];
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] cfgv_ff, cfgv_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [5:0]         rsp_id_ff, rsp_id_in;
   logic [CNT_W-1:0]   rsp_rem_ff, rsp_rem_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic [SLOT_W-1:0]  rd_addr;
   logic               nx_we, pv_we, dl_we, cf_we;
   logic [SLOT_W-1:0]  nx_waddr, pv_waddr, dl_waddr;
   logic [LINK_W-1:0]  nx_wdata, pv_wdata;
   logic [CNT_W-1:0]   dl_wdata;
   logic [LINK_W-1:0]  rd_next, rd_prev;
   logic [CNT_W-1:0]   rd_delta;
   logic [SLOT_W-1:0]  cf_raddr;
   logic [CFG_W-1:0]   cf_wdata, cf_rdata;

   logic               req_take, out_free;
   logic [LIST_W-1:0]  cf_list, st_list;
   logic [CNT_W-1:0]   cf_dur, st_dur;
   logic [CNT_W:0]     cum_sum;
   logic [CNT_W-1:0]   r_take, new_d, ds;
   logic               is_tick, ul_done, ul_more;

   dltq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_next_ram (
      .clock(clock), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
      .raddr(rd_addr), .rdata(rd_next));
   dltq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
      .clock(clock), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
      .raddr(rd_addr), .rdata(rd_prev));
   dltq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_delta_ram (
      .clock(clock), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
      .raddr(rd_addr), .rdata(rd_delta));
   // Start record of each slot: list and duration of its last start.
   dltq_ram #(.WIDTH(CFG_W), .DEPTH(NUM_SLOTS)) u_cfg_ram (
      .clock(clock), .we(cf_we), .waddr(id_ff), .wdata(cf_wdata),
      .raddr(cf_raddr), .rdata(cf_rdata));

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_tick   = (act_ff == ACT_TICK);

   // The start record read is issued with the request, so it is ready in decode.
   assign cf_raddr = SLOT_W'(req_timer_id);
   assign cf_list  = cfgv_ff[id_ff] ? cf_rdata[CFG_W-1:CNT_W] : '0;
   assign cf_dur   = cfgv_ff[id_ff] ? cf_rdata[CNT_W-1:0] : '0;

   assign cum_sum = {1'b0, cum_ff} + {1'b0, rd_delta};
   assign r_take  = (amt_ff < rd_delta) ? amt_ff : rd_delta;
   assign new_d   = rd_delta - r_take;
   assign ds      = is_tick ? '0 : rd_delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         cfgv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i] <= NONE_LINK;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         cfgv_ff      <= cfgv_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      id_ff         <= id_in;
      lt_ff         <= lt_in;
      amt_ff        <= amt_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      cum_ff        <= cum_in;
      v_ff          <= v_in;
      lst_ff        <= lst_in;
      ul_list_ff    <= ul_list_in;
      nxr_ff        <= nxr_in;
      pvr_ff        <= pvr_in;
      dr_ff         <= dr_in;
      em_status_ff  <= em_status_in;
      em_id_ff      <= em_id_in;
      em_rem_ff     <= em_rem_in;
      em_last_ff    <= em_last_in;
      em_next_ff    <= em_next_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      id_in        = id_ff;
      lt_in        = lt_ff;
      amt_in       = amt_ff;
      slot_in      = slot_ff;
      cur_in       = cur_ff;
      cum_in       = cum_ff;
      v_in         = v_ff;
      lst_in       = lst_ff;
      ul_list_in   = ul_list_ff;
      nxr_in       = nxr_ff;
      pvr_in       = pvr_ff;
      dr_in        = dr_ff;
      em_status_in = em_status_ff;
      em_id_in     = em_id_ff;
      em_rem_in    = em_rem_ff;
      em_last_in   = em_last_ff;
      em_next_in   = em_next_ff;
      head_in      = head_ff;
      active_in    = active_ff;
      cfgv_in      = cfgv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr  = slot_ff;
      nx_we    = 1'b0;
      nx_waddr = slot_ff;
      nx_wdata = NONE_LINK;
      pv_we    = 1'b0;
      pv_waddr = slot_ff;
      pv_wdata = NONE_LINK;
      dl_we    = 1'b0;
      dl_waddr = slot_ff;
      dl_wdata = v_ff;
      cf_we    = 1'b0;
      cf_wdata = {lst_ff, v_ff};
      st_list  = cf_list;
      st_dur   = cf_dur;
      ul_done  = 1'b0;
      ul_more  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in   = req_action;
               id_in    = SLOT_W'(req_timer_id);
               lt_in    = req_list_type;
               amt_in   = CNT_W'(req_amount);
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            em_id_in   = '0;
            em_rem_in  = '0;
            em_last_in = 1'b1;
            em_next_in = S_IDLE;
            em_status_in = ST_DONE;
            state_in   = S_EMIT;
            if (act_ff == ACT_START || act_ff == ACT_RESTART) begin
               if (act_ff == ACT_START) begin
                  st_list = LIST_W'(lt_ff);
                  st_dur  = amt_ff;
               end
               if (int'(lt_ff) >= NUM_LISTS && act_ff == ACT_START) begin
                  em_status_in = ST_BAD_LIST;
               end else if (st_dur == '0) begin
                  em_status_in = ST_ZERO_DUR;
               end else begin
                  cf_we      = 1'b1;
                  cf_wdata   = {st_list, st_dur};
                  cfgv_in[id_ff] = 1'b1;
                  lst_in     = st_list;
                  v_in       = st_dur;
                  ul_list_in = cf_list;
                  slot_in    = id_ff;
                  rd_addr    = id_ff;
                  state_in   = active_ff[id_ff] ? S_UL_A : S_LK_START;
               end
            end else if (act_ff == ACT_STOP) begin
               if (active_ff[id_ff]) begin
                  ul_list_in = cf_list;
                  slot_in    = id_ff;
                  rd_addr    = id_ff;
                  state_in   = S_UL_A;
               end else begin
                  em_status_in = ST_INACTIVE;
               end
            end else if (act_ff == ACT_QUERY) begin
               if (active_ff[id_ff]) begin
                  cum_in   = '0;
                  rd_addr  = id_ff;
                  state_in = S_QR_WALK;
               end else begin
                  em_status_in = ST_INACTIVE;
               end
            end else if (act_ff == ACT_TICK) begin
               if (int'(lt_ff) >= NUM_LISTS) begin
                  em_status_in = ST_BAD_LIST;
               end else if (!is_null(head_ff[LIST_W'(lt_ff)])) begin
                  ul_list_in = LIST_W'(lt_ff);
                  slot_in    = SLOT_W'(head_ff[LIST_W'(lt_ff)]);
                  rd_addr    = SLOT_W'(head_ff[LIST_W'(lt_ff)]);
                  state_in   = S_TK_CHK;
               end
            end
         end

         // Head of the ticked list is in the read data.
         S_TK_CHK: begin
            if (rd_delta > amt_ff) begin
               dl_we        = 1'b1;
               dl_waddr     = slot_ff;
               dl_wdata     = rd_delta - amt_ff;
               em_status_in = ST_DONE;
               em_id_in     = '0;
               em_rem_in    = '0;
               em_last_in   = 1'b1;
               em_next_in   = S_IDLE;
               state_in     = S_EMIT;
            end else begin
               amt_in   = amt_ff - rd_delta;
               rd_addr  = slot_ff;
               state_in = S_UL_A;
            end
         end

         S_TK_NEXT: begin
            rd_addr  = slot_ff;
            state_in = S_UL_A;
         end

         // Unlink, first half: fix the forward link past the slot and the successor's back link.
         S_UL_A: begin
            active_in[slot_ff] = 1'b0;
            if (!is_null(rd_prev)) begin
               nx_we    = 1'b1;
               nx_waddr = SLOT_W'(rd_prev);
               nx_wdata = rd_next;
            end else begin
               head_in[ul_list_ff] = rd_next;
            end
            if (!is_null(rd_next)) begin
               pv_we    = 1'b1;
               pv_waddr = SLOT_W'(rd_next);
               pv_wdata = rd_prev;
               rd_addr  = SLOT_W'(rd_next);
               dr_in    = ds;
               nxr_in   = rd_next;
               state_in = S_UL_B;
            end else begin
               ul_done = 1'b1;
            end
         end

         // Unlink, second half: the successor takes over the slot's delta.
         // On a tick the leftover units are charged to the new head instead.
         S_UL_B: begin
            dl_we    = 1'b1;
            dl_waddr = SLOT_W'(nxr_ff);
            if (is_tick) begin
               dl_wdata = new_d;
               amt_in   = amt_ff - r_take;
               ul_more  = (new_d == '0);
            end else begin
               dl_wdata = rd_delta + dr_ff;
            end
            ul_done = 1'b1;
         end

         S_LK_START: begin
            if (is_null(head_ff[lst_ff])) begin
               nx_we    = 1'b1;
               nx_waddr = slot_ff;
               nx_wdata = NONE_LINK;
               pv_we    = 1'b1;
               pv_waddr = slot_ff;
               pv_wdata = NONE_LINK;
               dl_we    = 1'b1;
               dl_waddr = slot_ff;
               dl_wdata = v_ff;
               head_in[lst_ff]    = LINK_W'(slot_ff);
               active_in[slot_ff] = 1'b1;
               em_status_in = ST_DONE;
               em_id_in     = '0;
               em_rem_in    = '0;
               em_last_in   = 1'b1;
               em_next_in   = S_IDLE;
               state_in     = S_EMIT;
            end else begin
               cur_in   = SLOT_W'(head_ff[lst_ff]);
               rd_addr  = SLOT_W'(head_ff[lst_ff]);
               cum_in   = '0;
               state_in = S_LK_WALK;
            end
         end

         // One list entry per cycle until the new timer's place is found.
         S_LK_WALK: begin
            if ({1'b0, v_ff} <= cum_sum) begin
               nx_we    = 1'b1;
               nx_waddr = slot_ff;
               nx_wdata = LINK_W'(cur_ff);
               pv_we    = 1'b1;
               pv_waddr = slot_ff;
               pv_wdata = rd_prev;
               dl_we    = 1'b1;
               dl_waddr = slot_ff;
               dl_wdata = v_ff - cum_ff;
               pvr_in   = rd_prev;
               dr_in    = rd_delta - (v_ff - cum_ff);
               state_in = S_LK_FIX;
            end else if (is_null(rd_next)) begin
               nx_we    = 1'b1;
               nx_waddr = cur_ff;
               nx_wdata = LINK_W'(slot_ff);
               pv_we    = 1'b1;
               pv_waddr = slot_ff;
               pv_wdata = LINK_W'(cur_ff);
               dl_we    = 1'b1;
               dl_waddr = slot_ff;
               dl_wdata = v_ff - cum_sum[CNT_W-1:0];
               state_in = S_LK_TAIL;
            end else begin
               cum_in  = cum_sum[CNT_W-1:0];
               cur_in  = SLOT_W'(rd_next);
               rd_addr = SLOT_W'(rd_next);
            end
         end

         S_LK_FIX: begin
            if (!is_null(pvr_ff)) begin
               nx_we    = 1'b1;
               nx_waddr = SLOT_W'(pvr_ff);
               nx_wdata = LINK_W'(slot_ff);
            end else begin
               head_in[lst_ff] = LINK_W'(slot_ff);
            end
            pv_we    = 1'b1;
            pv_waddr = cur_ff;
            pv_wdata = LINK_W'(slot_ff);
            dl_we    = 1'b1;
            dl_waddr = cur_ff;
            dl_wdata = dr_ff;
            active_in[slot_ff] = 1'b1;
            em_status_in = ST_DONE;
            em_id_in     = '0;
            em_rem_in    = '0;
            em_last_in   = 1'b1;
            em_next_in   = S_IDLE;
            state_in     = S_EMIT;
         end

         S_LK_TAIL: begin
            nx_we    = 1'b1;
            nx_waddr = slot_ff;
            nx_wdata = NONE_LINK;
            active_in[slot_ff] = 1'b1;
            em_status_in = ST_DONE;
            em_id_in     = '0;
            em_rem_in    = '0;
            em_last_in   = 1'b1;
            em_next_in   = S_IDLE;
            state_in     = S_EMIT;
         end

         // Remaining time is the sum of deltas back to the head.
         S_QR_WALK: begin
            if (is_null(rd_prev)) begin
               em_status_in = ST_DONE;
               em_id_in     = '0;
               em_rem_in    = cum_sum[CNT_W-1:0];
               em_last_in   = 1'b1;
               em_next_in   = S_IDLE;
               state_in     = S_EMIT;
            end else begin
               cum_in  = cum_sum[CNT_W-1:0];
               rd_addr = SLOT_W'(rd_prev);
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = em_status_ff;
               rsp_id_in     = em_id_ff;
               rsp_rem_in    = em_rem_ff;
               rsp_last_in   = em_last_ff;
               state_in      = em_next_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Where an unlink goes on depends on the request that caused it.
      if (ul_done) begin
         em_id_in   = '0;
         em_rem_in  = '0;
         em_last_in = 1'b1;
         em_next_in = S_IDLE;
         em_status_in = ST_DONE;
         state_in   = S_EMIT;
         if (act_ff == ACT_START || act_ff == ACT_RESTART) begin
            state_in = S_LK_START;
         end else if (is_tick) begin
            em_status_in = ST_EXPIRED;
            em_id_in     = 6'(slot_ff);
            em_last_in   = !ul_more;
            em_next_in   = ul_more ? S_TK_NEXT : S_IDLE;
            if (ul_more) begin
               slot_in = SLOT_W'(nxr_ff);
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_remaining  = 32'(rsp_rem_ff);
   assign rsp_last       = rsp_last_ff;

   // A taken request always goes to decode next.
   a_take_decode: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_DECODE)
      else $error("request taken but decode skipped");

   // No memory write while the sequencer is idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !(nx_we || pv_we || dl_we || cf_we))
      else $error("memory write while idle");

   // A staged response is loaded once the output register frees up.
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && out_free |=> rsp_valid_ff)
      else $error("response not loaded");

   // A timer linked at the tail is active once its link completes.
   a_tail_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LK_TAIL |=> active_ff[$past(slot_ff)])
      else $error("linked timer not active");
endmodule

/* tb/dltq_checker.sv */
// Scoreboard for the delta-list timer queue: watches both channels, keeps its
// own copy of the lists and compares every response. Depends on dltq_pkg.
`timescale 1ns / 1ps
module dltq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_timer_id,
   input  logic [1:0]  req_list_type,
   input  logic [31:0] req_amount,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [5:0]  rsp_expired_id,
   input  logic [31:0] rsp_remaining,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count,
   output int          expiry_count
);
   import dltq_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  expired_id;
      logic [31:0] remaining;
      logic        last;
   } timer_rsp_t;

   timer_rsp_t rsp_queue[$];

   logic [LINK_W-1:0] head_q [NUM_LISTS];
   logic [LINK_W-1:0] nxt_q  [NUM_SLOTS];
   logic [LINK_W-1:0] prv_q  [NUM_SLOTS];
   logic [CNT_W-1:0]  delta_q[NUM_SLOTS];
   logic              act_q  [NUM_SLOTS];
   logic [LIST_W-1:0] list_q [NUM_SLOTS];
   logic [CNT_W-1:0]  dur_q  [NUM_SLOTS];

   function automatic timer_rsp_t mk(status_type st, logic [5:0] id, logic [31:0] rem);
      timer_rsp_t r;
      r.status = st;
      r.expired_id = id;
      r.remaining = rem;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic detach(int s);
      logic [LINK_W-1:0] nx, pv;
      nx = nxt_q[s];
      pv = prv_q[s];
      act_q[s] = 1'b0;
      if (!is_null(nx)) begin
         delta_q[nx] = delta_q[nx] + delta_q[s];
         prv_q[nx] = pv;
      end
      if (!is_null(pv)) nxt_q[pv] = nx;
      else head_q[list_q[s]] = nx;
   endtask

   task automatic attach(int s);
      logic [LINK_W-1:0] cur, pv;
      logic [CNT_W-1:0] v, cum;
      v = dur_q[s];
      cum = '0;
      act_q[s] = 1'b1;
      cur = head_q[list_q[s]];
      if (is_null(cur)) begin
         head_q[list_q[s]] = LINK_W'(s);
         nxt_q[s] = NONE_LINK;
         prv_q[s] = NONE_LINK;
         delta_q[s] = v;
         return;
      end
      while (!is_null(cur)) begin
         cum += delta_q[cur];
         if (v <= cum) begin
            pv = prv_q[cur];
            nxt_q[s] = cur;
            prv_q[s] = pv;
            if (!is_null(pv)) nxt_q[pv] = LINK_W'(s);
            else head_q[list_q[s]] = LINK_W'(s);
            prv_q[cur] = LINK_W'(s);
            delta_q[s] = v - (cum - delta_q[cur]);
            delta_q[cur] = delta_q[cur] - delta_q[s];
            return;
         end
         if (is_null(nxt_q[cur])) begin
            nxt_q[cur] = LINK_W'(s);
            nxt_q[s] = NONE_LINK;
            prv_q[s] = cur;
            delta_q[s] = v - cum;
            return;
         end
         cur = nxt_q[cur];
      end
   endtask

   // Applies one request to the shadow lists and queues its responses.
   task automatic predict_timer_op(logic [2:0] act, logic [5:0] id, logic [1:0] lt,
                                   logic [31:0] amt);
      timer_rsp_t r[$];
      logic [LINK_W-1:0] h, cur;
      logic [CNT_W-1:0] left, take, d;
      logic [LIST_W-1:0] lsel;
      logic [63:0] sum;
      left = amt;
      if (act == ACT_TICK) begin
         h = head_q[lt];
         if (!is_null(h)) begin
            if (delta_q[h] > left) delta_q[h] -= left;
            else begin
               left -= delta_q[h];
               delta_q[h] = 0;
               while (!is_null(h) && delta_q[h] == 0) begin
                  detach(h);
                  r.push_back(mk(ST_EXPIRED, h[5:0], 0));
                  h = head_q[lt];
                  if (is_null(h)) break;
                  take = left < delta_q[h] ? left : delta_q[h];
                  delta_q[h] -= take;
                  left -= take;
               end
            end
         end
         if (r.size() == 0) r.push_back(mk(ST_DONE, 0, 0));
      end else if (act == ACT_START || act == ACT_RESTART) begin
         lsel = act == ACT_START ? lt : list_q[id];
         d = act == ACT_START ? amt : dur_q[id];
         if (d == 0) r.push_back(mk(ST_ZERO_DUR, 0, 0));
         else begin
            if (act_q[id]) detach(id);
            list_q[id] = lsel;
            dur_q[id] = d;
            attach(id);
            r.push_back(mk(ST_DONE, 0, 0));
         end
      end else if (act == ACT_STOP) begin
         if (act_q[id]) begin
            detach(id);
            r.push_back(mk(ST_DONE, 0, 0));
         end else r.push_back(mk(ST_INACTIVE, 0, 0));
      end else if (act == ACT_QUERY) begin
         if (!act_q[id]) r.push_back(mk(ST_INACTIVE, 0, 0));
         else begin
            sum = 0;
            cur = LINK_W'(id);
            while (!is_null(cur)) begin
               sum += 64'(delta_q[cur]);
               cur = prv_q[cur];
            end
            r.push_back(mk(ST_DONE, 0, sum[31:0]));
         end
      end else r.push_back(mk(ST_DONE, 0, 0));
      r[r.size()-1].last = 1'b1;
      foreach (r[i]) begin
         if (r[i].status == ST_EXPIRED) expiry_count++;
         rsp_queue.push_back(r[i]);
      end
   endtask

   always @(posedge clock) begin
      timer_rsp_t want;
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) head_q[i] = NONE_LINK;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            act_q[i] = 1'b0;
            list_q[i] = '0;
            dur_q[i] = '0;
            nxt_q[i] = '0;
            prv_q[i] = '0;
            delta_q[i] = '0;
         end
         rsp_queue.delete();
         fail_count = 0;
         expiry_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: status %0d id %0d rem %0d last %0d",
                           rsp_status, rsp_expired_id, rsp_remaining, rsp_last);
            end else begin
               want = rsp_queue.pop_front();
               if (want.status !== rsp_status || want.expired_id !== rsp_expired_id ||
                   want.remaining !== rsp_remaining || want.last !== rsp_last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp st %0d id %0d rem %0d last %0d, got %0d %0d %0d %0d",
                              want.status, want.expired_id, want.remaining, want.last,
                              rsp_status, rsp_expired_id, rsp_remaining, rsp_last);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_timer_op(req_action, req_timer_id, req_list_type, req_amount);
      end
      pending_count = rsp_queue.size();
   end
endmodule

/* tb/tb_delta_list_timer_queue_core.sv */
// Top of the delta-list timer queue testbench: clock, reset, request stimulus
// and the verdict. Depends on dltq_pkg, dltq_checker and the core.
`timescale 1ns / 1ps
module tb_delta_list_timer_queue_core;
   import dltq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [5:0]  req_timer_id = '0;
   logic [1:0]  req_list_type = '0;
   logic [31:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_expired_id;
   logic [31:0] rsp_remaining;
   logic        rsp_last;
   int          fail_count, pending_count, expiry_count;
   // While set, neither side inserts idle cycles.
   logic        no_idle = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   delta_list_timer_queue_core uut (.*);

   dltq_checker checker_i (.*);

   // The response side stalls at random, with a probability of 35 in a hundred, while no_idle is clear.
   always @(posedge clock)
      rsp_stall <= !no_idle && ($urandom_range(99) < 35);

   // Drives one request transaction and holds it until it is taken. A gap of
   // idle cycles is inserted in front at random.
   task automatic send_op(logic [2:0] act, logic [5:0] id, logic [1:0] lt, logic [31:0] amt);
      while (!no_idle && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_timer_id <= id;
      req_list_type <= lt;
      req_amount <= amt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Short durations keep the lists crowded so ticks expire several timers;
   // a few wide values reach the top of the count range.
   function automatic logic [31:0] pick_amount();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 40);
      if (r < 85) return $urandom_range(0, 400);
      return $urandom();
   endfunction

   initial begin
      logic [2:0] act;
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed part: every action, zero durations, equal times, extremes.
      send_op(ACT_RESTART, 6'd5, 2'd0, 32'd0);        // never started
      send_op(ACT_STOP, 6'd5, 2'd0, 32'd0);           // inactive stop
      send_op(ACT_QUERY, 6'd63, 2'd3, 32'd0);         // inactive query
      send_op(ACT_START, 6'd1, 2'd0, 32'd0);          // zero duration
      send_op(ACT_TICK, 6'd0, 2'd2, 32'd5);           // empty list
      send_op(ACT_START, 6'd0, 2'd0, 32'd10);
      send_op(ACT_START, 6'd1, 2'd0, 32'd10);         // equal time
      send_op(ACT_START, 6'd2, 2'd0, 32'd4);
      send_op(ACT_START, 6'd63, 2'd3, 32'hFFFF_FFFF);
      send_op(ACT_START, 6'd62, 2'd3, 32'hFFFF_FFFE);
      send_op(ACT_QUERY, 6'd0, 2'd0, 32'd0);
      send_op(ACT_QUERY, 6'd63, 2'd0, 32'd0);
      send_op(ACT_START, 6'd2, 2'd1, 32'd7);          // active start moves list
      send_op(ACT_RESTART, 6'd2, 2'd0, 32'd0);        // active restart
      send_op(ACT_START, 6'd0, 2'd0, 32'd0);          // zero keeps it active
      send_op(ACT_STOP, 6'd1, 2'd0, 32'd0);
      send_op(ACT_TICK, 6'd0, 2'd0, 32'd3);           // no expiry
      send_op(ACT_TICK, 6'd0, 2'd0, 32'd20);          // expiry
      send_op(ACT_TICK, 6'd0, 2'd1, 32'd7);
      send_op(3'd5, 6'd0, 2'd0, 32'd0);               // unused action codes
      send_op(3'd7, 6'h2A, 2'd1, 32'h5555_5555);
      send_op(ACT_TICK, 6'd0, 2'd3, 32'hFFFF_FFFF);   // everything on list 3
      // Random part, with a long stretch without idling in the middle.
      for (int n = 0; n < 430; n++) begin
         no_idle <= (n >= 150 && n < 230);
         r = $urandom_range(99);
         act = r < 40 ? ACT_START : r < 50 ? ACT_RESTART : r < 60 ? ACT_STOP :
               r < 72 ? ACT_QUERY : r < 97 ? ACT_TICK : 3'($urandom_range(5, 7));
         send_op(act, 6'($urandom_range(15)) | (($urandom_range(3) == 0) ? 6'($urandom()) : 6'd0),
                 2'($urandom()), act == ACT_TICK ? pick_amount() >> 1 : pick_amount());
      end
      req_valid <= 1'b0;
      no_idle <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("delta_list_timer_queue_core regression: pass");
      else
         $display("delta_list_timer_queue_core regression: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("delta_list_timer_queue_core regression: fail");
      $finish;
   end
endmodule
